// ===== hw/rtl/calendar_clock_with_alarm_defines.svh =====
// Assertion macros shared by the calendar clock RTL.
`ifndef CALENDAR_CLOCK_WITH_ALARM_DEFINES_SVH
`define CALENDAR_CLOCK_WITH_ALARM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CCA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CCA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cca_pkg.sv =====
// Shared types, constants and calendar functions for the calendar clock.
package cca_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned WDAY_W  = 3;
    localparam int unsigned CENT_W  = 7;
    localparam int unsigned CFG_W   = 6;
    localparam int unsigned IDX_W   = 2;

    localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
    localparam logic [HOUR_W-1:0]  HOUR_MAX  = 5'd23;
    localparam logic [MIN_W-1:0]   MIN_MAX   = 6'd59;
    localparam logic [SEC_W-1:0]   SEC_MAX   = 6'd59;
    localparam logic [CENT_W-1:0]  YR100_MAX = 7'd99;

    // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y
    localparam logic [12:0]        DIV100_MUL = 13'd5243;
    localparam int unsigned        DIV100_SH  = 19;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0]   DAYS_28 = 5'd28;
    localparam logic [DAY_W-1:0]   DAYS_29 = 5'd29;
    localparam logic [DAY_W-1:0]   DAYS_30 = 5'd30;
    localparam logic [DAY_W-1:0]   DAYS_31 = 5'd31;

    // Reset date and time: 2022-03-26 22:56:59
    localparam logic [YEAR_W-1:0]  RST_YEAR   = 14'd2022;
    localparam logic [CENT_W-1:0]  RST_CENT   = 7'd20;
    localparam logic [CENT_W-1:0]  RST_YR100  = 7'd22;
    localparam logic [MONTH_W-1:0] RST_MONTH  = 4'd3;
    localparam logic [DAY_W-1:0]   RST_DAY    = 5'd26;
    localparam logic [HOUR_W-1:0]  RST_HOUR   = 5'd22;
    localparam logic [MIN_W-1:0]   RST_MINUTE = 6'd56;
    localparam logic [SEC_W-1:0]   RST_SECOND = 6'd59;

    localparam logic [HOUR_W-1:0]  RST_AL_HOUR   = 5'd7;
    localparam logic [MIN_W-1:0]   RST_AL_MINUTE = 6'd30;
    localparam logic [SEC_W-1:0]   RST_AL_SECOND = 6'd0;

    typedef enum logic [IDX_W-1:0] {
        CFG_ALARM_HOUR   = 2'd0,
        CFG_ALARM_MINUTE = 2'd1,
        CFG_ALARM_SECOND = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } cca_time_t;

    // Load path output: cleaned beat plus year split into century and year-in-century
    typedef struct packed {
        logic               mode;
        cca_time_t          t;
        logic [CENT_W-1:0]  century;
        logic [CENT_W-1:0]  yr100;
    } cca_load_t;

    // Date and time after one beat, handed to the weekday pipeline
    typedef struct packed {
        cca_time_t          t;
        logic [CENT_W-1:0]  century;
        logic               yr100_zero;
    } cca_stage_t;

    typedef struct packed {
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } cca_alarm_t;

    typedef struct packed {
        cca_time_t          t;
        logic [WDAY_W-1:0]  weekday;
        logic               alarm_hit;
        logic               hour_chime;
    } cca_result_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            MONTH_FEB: len = leap ? DAYS_29 : DAYS_28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_30;
            default:   len = DAYS_31;
        endcase
        return len;
    endfunction

endpackage

// ===== hw/rtl/cca_load.sv =====
// Load path: input register, field saturation, year split and day clamp.
module cca_load import cca_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      s_mode,
    input  cca_time_t s_time,
    output logic      ld_valid,
    input  logic      ld_ready,
    output cca_load_t ld_data
);

    logic              in_valid_reg;
    logic              in_mode_reg;
    cca_time_t         in_time_reg;

    logic              a_valid_reg;
    logic              a_mode_reg;
    cca_time_t         a_time_reg;
    logic [CENT_W-1:0] a_cent_reg;

    logic              b_valid_reg;
    cca_load_t         b_data_reg;

    logic              b_ready;
    logic              a_ready;
    logic              in_ready;

    cca_time_t         a_time_next;
    logic [26:0]       a_prod;
    logic [CENT_W-1:0] a_cent_next;

    logic [YEAR_W-1:0] b_hund;
    logic [CENT_W-1:0] b_yr100;
    logic              b_leap;
    logic [DAY_W-1:0]  b_len;
    cca_load_t         b_data_next;

    assign b_ready  = !b_valid_reg || ld_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = !in_valid_reg || a_ready;
    assign s_ready  = in_ready;
    assign ld_valid = b_valid_reg;
    assign ld_data  = b_data_reg;

    // Saturate every field; day only gets its lower bound here
    always_comb begin
        a_time_next        = in_time_reg;
        if (in_time_reg.year == '0) begin
            a_time_next.year = YEAR_MIN;
        end else if (in_time_reg.year > YEAR_MAX) begin
            a_time_next.year = YEAR_MAX;
        end
        if (in_time_reg.month == '0) begin
            a_time_next.month = MONTH_JAN;
        end else if (in_time_reg.month > MONTH_MAX) begin
            a_time_next.month = MONTH_MAX;
        end
        if (in_time_reg.day == '0) begin
            a_time_next.day = DAY_W'(1);
        end
        if (in_time_reg.hour > HOUR_MAX) begin
            a_time_next.hour = HOUR_MAX;
        end
        if (in_time_reg.minute > MIN_MAX) begin
            a_time_next.minute = MIN_MAX;
        end
        if (in_time_reg.second > SEC_MAX) begin
            a_time_next.second = SEC_MAX;
        end
        a_prod      = 27'(a_time_next.year) * 27'(DIV100_MUL);
        a_cent_next = a_prod[DIV100_SH +: CENT_W];
    end

    // Year in century, leap flag and day clamp to month length
    always_comb begin
        b_hund  = YEAR_W'({a_cent_reg, 6'b0}) + YEAR_W'({a_cent_reg, 5'b0})
                + YEAR_W'({a_cent_reg, 2'b0});
        b_yr100 = CENT_W'(a_time_reg.year - b_hund);
        b_leap  = (a_time_reg.year[1:0] == 2'b00)
                && ((b_yr100 != '0) || (a_cent_reg[1:0] == 2'b00));
        b_len   = month_len(a_time_reg.month, b_leap);
        b_data_next         = '{mode: a_mode_reg, t: a_time_reg,
                                century: a_cent_reg, yr100: b_yr100};
        if (a_time_reg.day > b_len) begin
            b_data_next.t.day = b_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                in_valid_reg <= s_valid;
            end
            if (a_ready) begin
                a_valid_reg <= in_valid_reg;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && in_ready) begin
            in_mode_reg <= s_mode;
            in_time_reg <= s_time;
        end
        if (in_valid_reg && a_ready) begin
            a_mode_reg <= in_mode_reg;
            a_time_reg <= a_time_next;
            a_cent_reg <= a_cent_next;
        end
        if (a_valid_reg && b_ready) begin
            b_data_reg <= b_data_next;
        end
    end

endmodule

// ===== hw/rtl/cca_wday.sv =====
// Weekday pipeline, alarm and chime flags, and the result register.
module cca_wday import cca_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        st_valid,
    output logic        st_ready,
    input  cca_stage_t  st_data,
    input  cca_alarm_t  alarm,
    output logic        m_valid,
    input  logic        m_ready,
    output cca_result_t m_data
);

    function automatic logic [3:0] month_term(input logic [MONTH_W-1:0] m);
        logic [3:0] v;
        case (m)
            4'd3:    v = 4'd2;
            4'd4:    v = 4'd3;
            4'd5:    v = 4'd3;
            4'd6:    v = 4'd4;
            4'd7:    v = 4'd4;
            4'd8:    v = 4'd5;
            4'd9:    v = 4'd6;
            4'd10:   v = 4'd6;
            4'd11:   v = 4'd7;
            4'd12:   v = 4'd7;
            4'd13:   v = 4'd8;
            4'd14:   v = 4'd9;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

    // 8 == 1 mod 7: fold octal digits twice, then one subtract
    function automatic logic [2:0] mod7(input logic [14:0] v);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [3:0] s3;
        s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12]);
        s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
        s3 = (s2 >= 4'd7) ? (s2 - 4'd7) : s2;
        return s3[2:0];
    endfunction

    logic               p2_valid_reg;
    cca_time_t          p2_time_reg;
    logic [14:0]        p2_a_reg;
    logic [6:0]         p2_b_reg;
    logic [CENT_W-1:0]  p2_c_reg;
    logic               p2_alarm_reg;
    logic               p2_chime_reg;

    logic               p3_valid_reg;
    cca_time_t          p3_time_reg;
    logic [14:0]        p3_sum_reg;
    logic               p3_alarm_reg;
    logic               p3_chime_reg;

    logic               out_valid_reg;
    cca_result_t        out_data_reg;

    logic               out_ready;
    logic               p3_ready;
    logic               p2_ready;

    logic               early;
    logic [MONTH_W-1:0] m_adj;
    logic [YEAR_W-1:0]  y_adj;
    logic [CENT_W-1:0]  q_adj;
    logic [14:0]        p2_a_next;
    logic [6:0]         p2_b_next;
    logic [14:0]        p3_sum_next;

    assign out_ready = !out_valid_reg || m_ready;
    assign p3_ready  = !p3_valid_reg || out_ready;
    assign p2_ready  = !p2_valid_reg || p3_ready;
    assign st_ready  = p2_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    // January and February count as months 13 and 14 of the previous year
    always_comb begin
        early     = (st_data.t.month <= MONTH_FEB);
        m_adj     = early ? (st_data.t.month + MONTH_W'(12)) : st_data.t.month;
        y_adj     = early ? (st_data.t.year - YEAR_W'(1)) : st_data.t.year;
        q_adj     = (early && st_data.yr100_zero) ? (st_data.century - CENT_W'(1))
                                                  : st_data.century;
        p2_a_next = 15'(y_adj) + 15'(y_adj >> 2);
        p2_b_next = 7'(st_data.t.day) + 7'({m_adj, 1'b0}) + 7'(month_term(m_adj))
                  + 7'(q_adj >> 2);
    end

    assign p3_sum_next = p2_a_reg + 15'(p2_b_reg) - 15'(p2_c_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (p2_ready) begin
                p2_valid_reg <= st_valid;
            end
            if (p3_ready) begin
                p3_valid_reg <= p2_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= p3_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (st_valid && p2_ready) begin
            p2_time_reg  <= st_data.t;
            p2_a_reg     <= p2_a_next;
            p2_b_reg     <= p2_b_next;
            p2_c_reg     <= q_adj;
            p2_alarm_reg <= (st_data.t.hour == alarm.hour)
                         && (st_data.t.minute == alarm.minute)
                         && (st_data.t.second == alarm.second);
            p2_chime_reg <= (st_data.t.minute == '0) && (st_data.t.second == '0);
        end
        if (p2_valid_reg && p3_ready) begin
            p3_time_reg  <= p2_time_reg;
            p3_sum_reg   <= p3_sum_next;
            p3_alarm_reg <= p2_alarm_reg;
            p3_chime_reg <= p2_chime_reg;
        end
        if (p3_valid_reg && out_ready) begin
            out_data_reg.t          <= p3_time_reg;
            out_data_reg.weekday    <= mod7(p3_sum_reg) + WDAY_W'(1);
            out_data_reg.alarm_hit  <= p3_alarm_reg;
            out_data_reg.hour_chime <= p3_chime_reg;
        end
    end

endmodule

// ===== hw/rtl/calendar_clock_with_alarm.sv =====
// Top level of the calendar clock with alarm and hourly chime.
//
//  Channel   Ports                               Content
//  --------  ----------------------------------  -----------------------------------
//  input     s_tvalid s_tready s_tdata s_tuser   tick (tuser 0) or date/time load
//  result    m_tvalid m_tready m_tdata           date, time, weekday, alarm, chime
//  config    cfg_wr_en cfg_addr cfg_wdata        alarm hour, minute, second
//
//  One beat is accepted per cycle while s_tready is high; each beat yields one
//  result beat. The clock state updates through combinational carry logic,
//  so beats follow back to back. Reset gives 2022-03-26 22:56:59 and alarm 07:30:00.
//  A stalled result holds in the output register while bubbles further up
//  keep taking input beats; s_tready drops only when every stage is full.
`include "calendar_clock_with_alarm_defines.svh"

module calendar_clock_with_alarm import cca_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    // tdata: year[13:0], month[17:14], day[22:18], hour[27:23],
    //        minute[33:28], second[39:34]
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [39:0]      s_tdata,
    // tuser: mode[0] (0 tick, 1 load)
    input  logic             s_tuser,
    // tdata: year[13:0], month[17:14], day[22:18], hour[27:23],
    //        minute[33:28], second[39:34], weekday[42:40], alarm_hit[43],
    //        hour_chime[44], zero[47:45]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [47:0]      m_tdata,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata
);

    cca_time_t          s_time;

    logic               ld_valid;
    logic               ld_ready;
    cca_load_t          ld_data;
    logic               ld_take;

    // Running clock state
    logic [YEAR_W-1:0]  cur_year_reg,   cur_year_next;
    logic [CENT_W-1:0]  cur_cent_reg,   cur_cent_next;
    logic [CENT_W-1:0]  cur_yr100_reg,  cur_yr100_next;
    logic [MONTH_W-1:0] cur_month_reg,  cur_month_next;
    logic [DAY_W-1:0]   cur_day_reg,    cur_day_next;
    logic [HOUR_W-1:0]  cur_hour_reg,   cur_hour_next;
    logic [MIN_W-1:0]   cur_minute_reg, cur_minute_next;
    logic [SEC_W-1:0]   cur_second_reg, cur_second_next;
    logic               cur_leap;

    logic               st_valid_reg;
    cca_stage_t         st_data_reg;
    cca_stage_t         st_data_next;
    logic               wd_ready;

    cca_alarm_t         alarm_reg;

    logic               res_valid;
    cca_result_t        res_data;

    assign s_time = '{year:   s_tdata[13:0],  month:  s_tdata[17:14],
                      day:    s_tdata[22:18], hour:   s_tdata[27:23],
                      minute: s_tdata[33:28], second: s_tdata[39:34]};

    // Saturate and split the load fields ahead of the clock state
    cca_load u_load (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_mode   (s_tuser),
        .s_time   (s_time),
        .ld_valid (ld_valid),
        .ld_ready (ld_ready),
        .ld_data  (ld_data)
    );

    assign ld_ready = !st_valid_reg || wd_ready;
    assign ld_take  = ld_valid && ld_ready;

    assign cur_leap = (cur_year_reg[1:0] == 2'b00)
                   && ((cur_yr100_reg != '0) || (cur_cent_reg[1:0] == 2'b00));

    // Advance one second with carries, or take the loaded date and time
    always_comb begin
        cur_year_next   = cur_year_reg;
        cur_cent_next   = cur_cent_reg;
        cur_yr100_next  = cur_yr100_reg;
        cur_month_next  = cur_month_reg;
        cur_day_next    = cur_day_reg;
        cur_hour_next   = cur_hour_reg;
        cur_minute_next = cur_minute_reg;
        cur_second_next = cur_second_reg;
        if (ld_data.mode) begin
            cur_year_next   = ld_data.t.year;
            cur_cent_next   = ld_data.century;
            cur_yr100_next  = ld_data.yr100;
            cur_month_next  = ld_data.t.month;
            cur_day_next    = ld_data.t.day;
            cur_hour_next   = ld_data.t.hour;
            cur_minute_next = ld_data.t.minute;
            cur_second_next = ld_data.t.second;
        end else if (cur_second_reg != SEC_MAX) begin
            cur_second_next = cur_second_reg + SEC_W'(1);
        end else begin
            cur_second_next = '0;
            if (cur_minute_reg != MIN_MAX) begin
                cur_minute_next = cur_minute_reg + MIN_W'(1);
            end else begin
                cur_minute_next = '0;
                if (cur_hour_reg != HOUR_MAX) begin
                    cur_hour_next = cur_hour_reg + HOUR_W'(1);
                end else begin
                    cur_hour_next = '0;
                    if (cur_day_reg < month_len(cur_month_reg, cur_leap)) begin
                        cur_day_next = cur_day_reg + DAY_W'(1);
                    end else begin
                        cur_day_next = DAY_W'(1);
                        if (cur_month_reg != MONTH_DEC) begin
                            cur_month_next = cur_month_reg + MONTH_W'(1);
                        end else begin
                            cur_month_next = MONTH_JAN;
                            // wrap past the last year back to year one
                            if (cur_year_reg >= YEAR_MAX) begin
                                cur_year_next  = YEAR_MIN;
                                cur_cent_next  = '0;
                                cur_yr100_next = CENT_W'(1);
                            end else begin
                                cur_year_next = cur_year_reg + YEAR_W'(1);
                                if (cur_yr100_reg == YR100_MAX) begin
                                    cur_yr100_next = '0;
                                    cur_cent_next  = cur_cent_reg + CENT_W'(1);
                                end else begin
                                    cur_yr100_next = cur_yr100_reg + CENT_W'(1);
                                end
                            end
                        end
                    end
                end
            end
        end
        st_data_next = '{t: '{year: cur_year_next, month: cur_month_next,
                              day: cur_day_next, hour: cur_hour_next,
                              minute: cur_minute_next, second: cur_second_next},
                         century: cur_cent_next,
                         yr100_zero: (cur_yr100_next == '0)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_year_reg   <= RST_YEAR;
            cur_cent_reg   <= RST_CENT;
            cur_yr100_reg  <= RST_YR100;
            cur_month_reg  <= RST_MONTH;
            cur_day_reg    <= RST_DAY;
            cur_hour_reg   <= RST_HOUR;
            cur_minute_reg <= RST_MINUTE;
            cur_second_reg <= RST_SECOND;
            st_valid_reg   <= 1'b0;
        end else begin
            if (ld_take) begin
                cur_year_reg   <= cur_year_next;
                cur_cent_reg   <= cur_cent_next;
                cur_yr100_reg  <= cur_yr100_next;
                cur_month_reg  <= cur_month_next;
                cur_day_reg    <= cur_day_next;
                cur_hour_reg   <= cur_hour_next;
                cur_minute_reg <= cur_minute_next;
                cur_second_reg <= cur_second_next;
            end
            if (ld_ready) begin
                st_valid_reg <= ld_valid;
            end
        end
    end

    // Hold a copy of the new date and time for the weekday pipeline
    always_ff @(posedge aclk) begin
        if (ld_take) begin
            st_data_reg <= st_data_next;
        end
    end

    // Alarm registers; an unknown index is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alarm_reg <= '{hour: RST_AL_HOUR, minute: RST_AL_MINUTE,
                           second: RST_AL_SECOND};
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_ALARM_HOUR:   alarm_reg.hour   <= cfg_wdata[HOUR_W-1:0];
                CFG_ALARM_MINUTE: alarm_reg.minute <= cfg_wdata[MIN_W-1:0];
                CFG_ALARM_SECOND: alarm_reg.second <= cfg_wdata[SEC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    cca_wday u_wday (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .st_valid (st_valid_reg),
        .st_ready (wd_ready),
        .st_data  (st_data_reg),
        .alarm    (alarm_reg),
        .m_valid  (res_valid),
        .m_ready  (m_tready),
        .m_data   (res_data)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = {3'b000, res_data.hour_chime, res_data.alarm_hit, res_data.weekday,
                       res_data.t.second, res_data.t.minute, res_data.t.hour,
                       res_data.t.day, res_data.t.month, res_data.t.year};

    // Time of day never leaves its range
    `CCA_ASSERT_NOW(a_time_range, aclk, aresetn, 1'b1, (cur_second_reg <= SEC_MAX) && (cur_minute_reg <= MIN_MAX) && (cur_hour_reg <= HOUR_MAX), "clock state out of range")

    // Century and year-in-century track the year
    `CCA_ASSERT_NOW(a_year_split, aclk, aresetn, 1'b1, ((YEAR_W'(cur_cent_reg) * YEAR_W'(100)) + YEAR_W'(cur_yr100_reg)) == cur_year_reg, "year split out of step")

    // A tick without second carry bumps the second and leaves the minute
    `CCA_ASSERT_NEXT(a_tick_second, aclk, aresetn, ld_take && !ld_data.mode && (cur_second_reg != SEC_MAX), (cur_second_reg == ($past(cur_second_reg) + SEC_W'(1))) && $stable(cur_minute_reg), "tick did not advance second")

endmodule

// ===== test/tb_calendar_clock_with_alarm.sv =====
// Self-checking testbench for the calendar clock with alarm and hourly chime.
module tb_calendar_clock_with_alarm;
    timeunit 1ns;
    timeprecision 1ps;

    import cca_pkg::*;

    // Index 3 is decoded by nothing; writes there must leave the alarm alone.
    localparam logic [IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    localparam int RESULT_LATENCY = 6;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_BEATS    = 125;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [39:0]      s_tdata   = '0;
    logic             s_tuser   = 1'b0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [47:0]      m_tdata;
    logic             cfg_wr_en = 1'b0;
    logic [IDX_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // Shadow copy of the clock and alarm, advanced once per accepted beat
    cca_time_t   clock_now;
    cca_alarm_t  alarm_now;
    // Results still owed by the block, oldest first
    cca_result_t owed_results[$];

    int   mismatch_count = 0;
    int   cycle_count    = 0;
    int   calm_beats     = 0;     // beats left in a stretch with no input gaps
    int   ready_run      = 0;     // cycles left at the current m_tready level
    logic ready_level    = 1'b0;

    calendar_clock_with_alarm uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin : clock_gen
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Calendar arithmetic for the shadow clock
    // ------------------------------------------------------------------
    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in(input int unsigned y, input int unsigned m);
        case (m)
            MONTH_FEB: return leap_year(y) ? 29 : 28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
            default: return 31;
        endcase
    endfunction

    // January and February count as months 13 and 14 of the year before.
    function automatic int unsigned day_of_week(input int unsigned y, input int unsigned m,
                                                input int unsigned d);
        int unsigned yy;
        int unsigned mm;
        int unsigned sum;
        yy = y;
        mm = m;
        if (mm <= MONTH_FEB) begin
            mm += 12;
            yy -= 1;
        end
        sum = d + 2 * mm + (3 * (mm + 1)) / 5 + yy + yy / 4 - yy / 100 + yy / 400;
        return sum % 7 + 1;
    endfunction

    function automatic int unsigned clamp(input int unsigned v, input int unsigned lo,
                                          input int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Apply one beat to the shadow clock and return the result it owes.
    function automatic cca_result_t advance_clock(input logic mode, input cca_time_t raw);
        cca_result_t r;
        if (mode == MODE_LOAD) begin
            // saturate every field; the day clamps to the loaded month
            clock_now.year   = clamp(raw.year, YEAR_MIN, YEAR_MAX);
            clock_now.month  = clamp(raw.month, 1, MONTH_MAX);
            clock_now.day    = clamp(raw.day, 1, days_in(clock_now.year, clock_now.month));
            clock_now.hour   = clamp(raw.hour, 0, HOUR_MAX);
            clock_now.minute = clamp(raw.minute, 0, MIN_MAX);
            clock_now.second = clamp(raw.second, 0, SEC_MAX);
        end else if (clock_now.second < SEC_MAX) begin
            clock_now.second++;
        end else begin
            // carry up the chain; the year wraps from its top back to one
            clock_now.second = '0;
            if (clock_now.minute < MIN_MAX) begin
                clock_now.minute++;
            end else begin
                clock_now.minute = '0;
                if (clock_now.hour < HOUR_MAX) begin
                    clock_now.hour++;
                end else begin
                    clock_now.hour = '0;
                    if (clock_now.day < days_in(clock_now.year, clock_now.month)) begin
                        clock_now.day++;
                    end else begin
                        clock_now.day = 1;
                        if (clock_now.month < MONTH_MAX) begin
                            clock_now.month++;
                        end else begin
                            clock_now.month = MONTH_JAN;
                            clock_now.year  = (clock_now.year >= YEAR_MAX) ?
                                              YEAR_MIN : clock_now.year + 1;
                        end
                    end
                end
            end
        end
        r.t          = clock_now;
        r.weekday    = day_of_week(clock_now.year, clock_now.month, clock_now.day);
        r.alarm_hit  = (clock_now.hour == alarm_now.hour) &&
                       (clock_now.minute == alarm_now.minute) &&
                       (clock_now.second == alarm_now.second);
        r.hour_chime = (clock_now.minute == 0) && (clock_now.second == 0);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input side: pacing, beat driver, register writes
    // ------------------------------------------------------------------
    // Mostly back to back or short gaps, now and then a long hold-off,
    // and occasional stretches with no gaps at all.
    function automatic int input_gap();
        int r;
        if (calm_beats > 0) begin
            calm_beats--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm_beats = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic cca_time_t noise_bits();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[39:0];
    endfunction

    // Drive one beat and hold it until the block takes it. Valid stays high
    // on return so the next beat can follow without a bubble.
    task automatic send_beat(input logic mode, input cca_time_t raw);
        int gap;
        gap = input_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {raw.second, raw.minute, raw.hour, raw.day, raw.month, raw.year};
        owed_results.push_back(advance_clock(mode, raw));
        do @(posedge aclk); while (!s_tready);
    endtask

    // Ticks carry junk in tdata; the block must ignore it.
    task automatic send_tick();
        send_beat(MODE_TICK, noise_bits());
    endtask

    task automatic send_load(input int unsigned y, input int unsigned mo, input int unsigned d,
                             input int unsigned h, input int unsigned mi, input int unsigned s);
        cca_time_t t;
        t.year   = y;
        t.month  = mo;
        t.day    = d;
        t.hour   = h;
        t.minute = mi;
        t.second = s;
        send_beat(MODE_LOAD, t);
    endtask

    // Drop valid, wait for every owed result, then let the pipeline settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (owed_results.size() != 0) @(posedge aclk);
        repeat (RESULT_LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_ALARM_HOUR:   alarm_now.hour   = val[HOUR_W-1:0];
            CFG_ALARM_MINUTE: alarm_now.minute = val[MIN_W-1:0];
            CFG_ALARM_SECOND: alarm_now.second = val[SEC_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_alarm(input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] m,
                               input logic [CFG_W-1:0] s);
        write_reg(CFG_ALARM_HOUR, h);
        write_reg(CFG_ALARM_MINUTE, m);
        write_reg(CFG_ALARM_SECOND, s);
    endtask

    // ------------------------------------------------------------------
    // Output side: ready pacing and result check
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : ready_pacing
        if (ready_run == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    ready_level = 1'b1;
                    ready_run   = $urandom_range(1, 12);
                end
                5, 6, 7: begin
                    ready_level = 1'b0;
                    ready_run   = $urandom_range(1, 3);
                end
                8: begin
                    ready_level = 1'b0;
                    ready_run   = $urandom_range(10, 40);
                end
                default: begin
                    // long stretch with no back-pressure
                    ready_level = 1'b1;
                    ready_run   = $urandom_range(40, 120);
                end
            endcase
        end
        ready_run--;
        m_tready <= ready_level;
    end

    function automatic cca_result_t unpack_result(input logic [47:0] d);
        cca_result_t r;
        r.t.year     = d[13:0];
        r.t.month    = d[17:14];
        r.t.day      = d[22:18];
        r.t.hour     = d[27:23];
        r.t.minute   = d[33:28];
        r.t.second   = d[39:34];
        r.weekday    = d[42:40];
        r.alarm_hit  = d[43];
        r.hour_chime = d[44];
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t ns: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
            flag_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
    endtask

    always @(posedge aclk) begin : result_check
        cca_result_t got;
        cca_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = unpack_result(m_tdata);
            if (owed_results.size() == 0) begin
                flag_mismatch($sformatf("result beat with nothing owed: %0d-%0d-%0d %0d:%0d:%0d",
                                        got.t.year, got.t.month, got.t.day,
                                        got.t.hour, got.t.minute, got.t.second));
            end else begin
                want = owed_results.pop_front();
                compare_field("year",       want.t.year,     got.t.year);
                compare_field("month",      want.t.month,    got.t.month);
                compare_field("day",        want.t.day,      got.t.day);
                compare_field("hour",       want.t.hour,     got.t.hour);
                compare_field("minute",     want.t.minute,   got.t.minute);
                compare_field("second",     want.t.second,   got.t.second);
                compare_field("weekday",    want.weekday,    got.weekday);
                compare_field("alarm_hit",  want.alarm_hit,  got.alarm_hit);
                compare_field("hour_chime", want.hour_chime, got.hour_chime);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // First ticks run on from the reset date 2022-03-26 22:56:59.
    task automatic test_tick_from_reset();
        repeat (3) send_tick();
        drain();
    endtask

    // Minute, hour, day, month and year carries, leap Februaries and the
    // wrap from the last second of year 9999 to year one.
    task automatic test_calendar_carries();
        send_load(9999, 12, 31, 23, 59, 59);
        send_tick();
        send_load(2023, 2, 28, 23, 59, 59);
        send_tick();
        send_load(2024, 2, 28, 23, 59, 59);
        send_tick();
        send_load(2024, 2, 29, 23, 59, 59);
        send_tick();
        send_load(2022, 4, 30, 23, 59, 59);
        send_tick();
        drain();
    endtask

    // Out-of-range load fields saturate; day clamps to the month length,
    // including century years that are and are not leap.
    task automatic test_load_clamping();
        send_beat(MODE_LOAD, '0);
        send_beat(MODE_LOAD, '1);
        send_load(1900, 2, 31, 12, 0, 0);
        send_load(2000, 2, 31, 12, 0, 0);
        send_load(2021, 6, 31, 12, 0, 0);
        drain();
    endtask

    // Alarm at its reset value, at both extremes, out of range (never hits)
    // and unchanged by a write to the unmapped index.
    task automatic test_alarm_registers();
        send_load(2022, 5, 5, 7, 29, 59);
        send_tick();
        drain();
        write_alarm(0, 0, 0);
        send_load(2022, 5, 5, 23, 59, 59);
        send_tick();
        drain();
        write_alarm(HOUR_MAX, MIN_MAX, SEC_MAX);
        send_load(2022, 5, 5, 23, 59, 58);
        send_tick();
        drain();
        write_alarm(31, 63, 63);
        send_beat(MODE_LOAD, '1);
        drain();
        write_alarm(12, 0, 0);
        write_reg(CFG_UNMAPPED, '1);
        send_load(2022, 5, 5, 12, 0, 0);
        drain();
    endtask

    function automatic int unsigned pick_year();
        case ($urandom_range(0, 9))
            0: return YEAR_MAX;
            1: return YEAR_MIN;
            2: return 2000;
            3: return 1900;
            4: return 2024;
            5: return 2023;
            default: return $urandom_range(1, 9999);
        endcase
    endfunction

    // Loads are shaped to land just short of a carry or of the alarm so the
    // ticks that follow exercise the interesting transitions.
    function automatic cca_time_t random_load();
        cca_time_t   t;
        int unsigned r;
        int unsigned secs;
        r = $urandom_range(0, 19);
        t = noise_bits();
        if (r < 8) begin
            t.year   = pick_year();
            t.month  = ($urandom_range(0, 2) == 0) ? MONTH_DEC : $urandom_range(1, 12);
            t.day    = days_in(t.year, t.month) - $urandom_range(0, 1);
            t.hour   = HOUR_MAX;
            t.minute = MIN_MAX;
            t.second = $urandom_range(50, 59);
        end else if (r < 12) begin
            t.year  = pick_year();
            t.month = $urandom_range(1, 12);
            t.day   = $urandom_range(1, 31);
            secs = clamp(alarm_now.hour, 0, HOUR_MAX) * 3600 +
                   clamp(alarm_now.minute, 0, MIN_MAX) * 60 +
                   clamp(alarm_now.second, 0, SEC_MAX);
            secs = (secs + 86400 - $urandom_range(0, 8)) % 86400;
            t.hour   = secs / 3600;
            t.minute = (secs / 60) % 60;
            t.second = secs % 60;
        end else if (r < 17) begin
            t.year   = pick_year();
            t.month  = $urandom_range(1, 12);
            t.day    = $urandom_range(1, 31);
            t.hour   = $urandom_range(0, 23);
            t.minute = $urandom_range(0, 59);
            t.second = $urandom_range(0, 59);
        end
        // otherwise keep the raw noise: every field may be out of range
        return t;
    endfunction

    task automatic pick_alarm(input int phase);
        case (phase)
            0: write_alarm(0, 0, 0);
            1: write_alarm(HOUR_MAX, MIN_MAX, SEC_MAX);
            2: write_alarm($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63));
            3: begin
                write_alarm($urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
                write_reg(CFG_UNMAPPED, $urandom_range(0, 63));
            end
            default: begin
                // sometimes move only one register
                if ($urandom_range(0, 1) == 0)
                    write_reg(CFG_ALARM_MINUTE, $urandom_range(0, 59));
                else
                    write_alarm($urandom_range(0, 23), $urandom_range(0, 59),
                                $urandom_range(0, 59));
            end
        endcase
    endtask

    task automatic test_random_traffic();
        int phase;
        int n;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            pick_alarm(phase);
            for (n = 0; n < PHASE_BEATS; n++) begin
                if ($urandom_range(0, 9) == 0)
                    send_beat(MODE_LOAD, random_load());
                else
                    send_tick();
            end
            drain();
        end
    endtask

    // ------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : test_sequence
        // shadow state matches the block right after reset
        clock_now.year   = RST_YEAR;
        clock_now.month  = RST_MONTH;
        clock_now.day    = RST_DAY;
        clock_now.hour   = RST_HOUR;
        clock_now.minute = RST_MINUTE;
        clock_now.second = RST_SECOND;
        alarm_now.hour   = RST_AL_HOUR;
        alarm_now.minute = RST_AL_MINUTE;
        alarm_now.second = RST_AL_SECOND;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_tick_from_reset();
        test_calendar_carries();
        test_load_clamping();
        test_alarm_registers();
        test_random_traffic();

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== calendar_clock_with_alarm.f =====
+incdir+hw/rtl
hw/rtl/cca_pkg.sv
hw/rtl/cca_load.sv
hw/rtl/cca_wday.sv
hw/rtl/calendar_clock_with_alarm.sv
test/tb_calendar_clock_with_alarm.sv
